>>> src/tews_pkg.sv
package tews_pkg;

  localparam int TIME_W      = 40;
  localparam int ID_W        = 16;
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int OFF_W       = 6;
  localparam int LEN_W       = 7;
  localparam int FRAME_W     = 6;
  localparam int BATCH_FRAMES = 64;
  localparam int ENTRY_W     = TIME_W + ID_W;

  // Frame divider: quotient is at most the batch length, so seven bits suffice.
  localparam int QUOT_W  = 7;
  localparam int STEP_W  = 3;
  localparam int DIVS_W  = TIME_W + 1;
  localparam int DIVD_W  = TIME_W + LEN_W + 1;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 24;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_INS_RD = 8'b0000_0010,
    ST_INS_WR = 8'b0000_0100,
    ST_RUN_RD = 8'b0000_1000,
    ST_RUN_CK = 8'b0001_0000,
    ST_RUN_MU = 8'b0010_0000,
    ST_RUN_DV = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_t;

endpackage

>>> src/timed_event_window_scheduler_unit.sv
// Timed event window scheduler.
// The input channel (in_*) takes one beat per command; in_tuser holds the kind:
// insert an event time, run a batch window, or clear the table. The output
// channel (out_*) returns one or more beats per command, out_tlast on the final
// one. An insert returns the assigned id, or table_full when the table holds
// 64 events already. A run returns one beat per stored event inside
// [window_start, window_end) in time order, with its frame inside the batch,
// or a single beat with valid_res low when no event falls in the window.
// Events sit in a 64-entry table kept sorted by time then id; an insert walks
// the table from the top, moving larger entries up one slot, with a read state
// and a write state per moved entry. A run reads and checks each entry and, for
// a hit, computes the frame with a multiply state and a restoring divider.
// in_tready is high only while the sequencer is idle. Results leave through an
// output register, so a stalled receiver holds the sequencer only when a new
// beat must be handed over while the previous one still waits.
// Reset (rst_n low, synchronous) empties the table and sets the next id to zero;
// table contents themselves are not cleared, since only filled entries are read.
module timed_event_window_scheduler_unit import tews_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // event_time[39:0], window_start[79:40], window_end[119:80],
  // frame_offset[125:120], batch_length[132:126], zero pad above.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // event_id[15:0], frame_index[21:16], zero pad above.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // valid_res[0], table_full[1]
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  state_t state_r;

  logic [TIME_W-1:0] in_time, in_ws, in_we;
  logic [OFF_W-1:0]  in_off;
  logic [LEN_W-1:0]  in_len;
  logic              in_acc;

  assign in_time = in_tdata[39:0];
  assign in_ws   = in_tdata[79:40];
  assign in_we   = in_tdata[119:80];
  assign in_off  = in_tdata[125:120];
  assign in_len  = in_tdata[132:126];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc  = in_tvalid && in_tready;

  // Table and bookkeeping.
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [CNT_W-1:0]   count_r;
  logic [ID_W-1:0]    next_id_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   idx_m1;

  // Command operands.
  logic [TIME_W-1:0] ins_time_r;
  logic [ID_W-1:0]   ins_id_r;
  logic [TIME_W-1:0] ws_r, we_r, d_r, dt_r;
  logic [OFF_W-1:0]  off_r;
  logic [LEN_W-1:0]  len_r;
  logic [ID_W-1:0]   cur_id_r;

  // Held hit; it is sent only once the next hit or the end of the walk is known.
  logic              pend_r;
  logic [ID_W-1:0]   pend_id_r;
  logic [FRAME_W-1:0] pend_frame_r;

  // Final beat of the command.
  logic [ID_W-1:0]    res_id_r;
  logic [FRAME_W-1:0] res_frame_r;
  logic               res_valid_r, res_full_r;

  // Output register.
  logic               out_tvalid_r;
  logic [ID_W-1:0]    out_id_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic               out_valid_r, out_full_r, out_last_r;
  logic               out_free;
  logic               out_load;

  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_frame_r, out_id_r};
  assign out_tuser  = {out_full_r, out_valid_r};
  assign out_tlast  = out_last_r;

  // Memory port control.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, new_entry;
  logic [TIME_W-1:0]  rd_time;
  logic [ID_W-1:0]    rd_id;
  logic               move_up;

  assign idx_m1    = idx_r - 1'b1;
  assign new_entry = {ins_id_r, ins_time_r};
  assign rd_time   = rd_data_r[TIME_W-1:0];
  assign rd_id     = rd_data_r[ENTRY_W-1:TIME_W];
  // A stored entry moves up when it sorts after the new one.
  assign move_up   = (rd_time > ins_time_r) || (rd_time == ins_time_r && rd_id >= ins_id_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r[ADDR_W-1:0];
    mem_wdata = new_entry;
    mem_raddr = idx_r[ADDR_W-1:0];
    case (state_r)
      ST_INS_RD: begin
        mem_raddr = idx_m1[ADDR_W-1:0];
        mem_we    = (idx_r == '0);
      end
      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = move_up ? rd_data_r : new_entry;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Frame arithmetic: frame = offset + floor((2*len*dt + d) / (2*d)), clamped.
  // The sum gets one extra bit so that a large offset plus quotient cannot wrap.
  logic                  div_start, div_busy;
  logic [DIVD_W-1:0]     div_dividend;
  logic [QUOT_W-1:0]     div_quot;
  logic [LEN_W+TIME_W-1:0] prod;
  logic [QUOT_W:0]       frame_sum;
  logic [FRAME_W-1:0]    frame_clamped;

  assign prod         = len_r * dt_r;
  assign div_dividend = {prod, 1'b0} + DIVD_W'(d_r);
  assign div_start    = (state_r == ST_RUN_MU);
  assign frame_sum    = (QUOT_W+1)'(off_r) + (QUOT_W+1)'(div_quot);
  assign frame_clamped = (frame_sum >= (QUOT_W+1)'(BATCH_FRAMES)) ?
                         FRAME_W'(BATCH_FRAMES - 1) : frame_sum[FRAME_W-1:0];

  tews_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ({d_r, 1'b0}),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  // The output register is loaded with a held hit once the next frame is
  // ready, or with the final beat of the command.
  assign out_load = (state_r == ST_FIN && out_free) ||
                    (state_r == ST_RUN_DV && !div_busy && pend_r && out_free);

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      next_id_r    <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            res_frame_r <= '0;
            res_valid_r <= 1'b0;
            pend_r      <= 1'b0;
            case (in_tuser)
              KIND_INSERT: begin
                if (count_r == CNT_W'(TABLE_DEPTH)) begin
                  res_id_r   <= '0;
                  res_full_r <= 1'b1;
                  idx_r      <= '0;
                  state_r    <= ST_FIN;
                end else begin
                  ins_time_r <= in_time;
                  ins_id_r   <= next_id_r;
                  res_id_r   <= next_id_r;
                  res_full_r <= 1'b0;
                  next_id_r  <= next_id_r + 1'b1;
                  idx_r      <= count_r;
                  state_r    <= ST_INS_RD;
                end
              end
              KIND_RUN: begin
                res_id_r   <= '0;
                res_full_r <= 1'b0;
                idx_r      <= '0;
                ws_r  <= in_ws;
                we_r  <= in_we;
                d_r   <= in_we - in_ws;
                off_r <= in_off;
                len_r <= in_len;
                if (in_we > in_ws) begin
                  state_r <= ST_RUN_RD;
                end else begin
                  state_r <= ST_FIN;
                end
              end
              KIND_CLEAR: begin
                res_id_r   <= '0;
                res_full_r <= 1'b0;
                idx_r      <= '0;
                count_r    <= '0;
                state_r    <= ST_FIN;
              end
              default: begin
                res_id_r   <= '0;
                res_full_r <= 1'b0;
                idx_r      <= '0;
                state_r    <= ST_FIN;
              end
            endcase
          end
        end
        ST_INS_RD: begin
          if (idx_r == '0) begin
            count_r <= count_r + 1'b1;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_INS_WR;
          end
        end
        ST_INS_WR: begin
          if (move_up) begin
            idx_r   <= idx_m1;
            state_r <= ST_INS_RD;
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= ST_FIN;
          end
        end
        ST_RUN_RD: begin
          if (idx_r == count_r) begin
            if (pend_r) begin
              res_id_r    <= pend_id_r;
              res_frame_r <= pend_frame_r;
              res_valid_r <= 1'b1;
            end
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_RUN_CK;
          end
        end
        ST_RUN_CK: begin
          if (rd_time >= ws_r && rd_time < we_r) begin
            dt_r     <= rd_time - ws_r;
            cur_id_r <= rd_id;
            state_r  <= ST_RUN_MU;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_RUN_RD;
          end
        end
        ST_RUN_MU: begin
          state_r <= ST_RUN_DV;
        end
        ST_RUN_DV: begin
          if (!div_busy && (!pend_r || out_free)) begin
            if (pend_r) begin
              out_id_r     <= pend_id_r;
              out_frame_r  <= pend_frame_r;
              out_valid_r  <= 1'b1;
              out_full_r   <= 1'b0;
              out_last_r   <= 1'b0;
            end
            pend_r       <= 1'b1;
            pend_id_r    <= cur_id_r;
            pend_frame_r <= frame_clamped;
            idx_r        <= idx_r + 1'b1;
            state_r      <= ST_RUN_RD;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_id_r     <= res_id_r;
            out_frame_r  <= res_frame_r;
            out_valid_r  <= res_valid_r;
            out_full_r   <= res_full_r;
            out_last_r   <= 1'b1;
            pend_r       <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/tews_div.sv
module tews_div import tews_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [QUOT_W-1:0] quot
);

  // Restoring divider, one quotient bit per cycle, most significant first.
  logic              busy_r;
  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] sd_r;
  logic [QUOT_W-1:0] quot_r;
  logic [STEP_W-1:0] step_r;
  logic              ge;

  assign ge   = rem_r >= sd_r;
  assign busy = busy_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && step_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      sd_r   <= DIVD_W'({divisor, {(QUOT_W-1){1'b0}}});
      quot_r <= '0;
      step_r <= STEP_W'(QUOT_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - sd_r;
      end
      quot_r <= {quot_r[QUOT_W-2:0], ge};
      sd_r   <= sd_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

endmodule

>>> dv/tews_checker.sv
`timescale 1ns / 100ps
module tews_checker import tews_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending_beats
);

  typedef struct packed {
    logic [ID_W-1:0]    event_id;
    logic [FRAME_W-1:0] frame_index;
    logic               valid_res;
    logic               table_full;
    logic               last;
  } sched_beat_t;

  logic [TIME_W-1:0] sorted_times [TABLE_DEPTH];
  logic [ID_W-1:0]   sorted_ids   [TABLE_DEPTH];
  int                stored_count;
  logic [ID_W-1:0]   issue_id;
  sched_beat_t       due_beats [$];

  assign pending_beats = due_beats.size();

  function automatic sched_beat_t make_beat(logic [ID_W-1:0] id, logic [FRAME_W-1:0] fr,
                                            logic v, logic f, logic l);
    sched_beat_t b;
    b.event_id = id; b.frame_index = fr; b.valid_res = v; b.table_full = f; b.last = l;
    return b;
  endfunction

  task automatic schedule_command(logic [1:0] kind, logic [IN_DATA_W-1:0] d);
    logic [TIME_W-1:0] t, ws, we;
    logic [127:0]      span, num, fr;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    int                pos, hits;
    logic [ID_W-1:0]   id;
    sched_beat_t       tail;
    t = d[39:0]; ws = d[79:40]; we = d[119:80];
    off = d[125:120]; len = d[132:126];
    hits = 0;
    case (kind)
      KIND_INSERT: begin
        if (stored_count >= TABLE_DEPTH) begin
          due_beats.push_back(make_beat('0, '0, 1'b0, 1'b1, 1'b1));
        end else begin
          id = issue_id;
          issue_id++;
          pos = 0;
          while (pos < stored_count && (sorted_times[pos] < t ||
                 (sorted_times[pos] == t && sorted_ids[pos] < id)))
            pos++;
          for (int i = stored_count; i > pos; i--) begin
            sorted_times[i] = sorted_times[i-1];
            sorted_ids[i]   = sorted_ids[i-1];
          end
          sorted_times[pos] = t;
          sorted_ids[pos]   = id;
          stored_count++;
          due_beats.push_back(make_beat(id, '0, 1'b0, 1'b0, 1'b1));
        end
      end
      KIND_RUN: begin
        if (we > ws) begin
          span = we - ws;
          for (int i = 0; i < stored_count; i++) begin
            if (sorted_times[i] >= ws && sorted_times[i] < we) begin
              num = off * span + len * (sorted_times[i] - ws);
              fr  = (2 * num + span) / (2 * span);
              if (fr >= BATCH_FRAMES) fr = 128'(BATCH_FRAMES - 1);
              due_beats.push_back(make_beat(sorted_ids[i], fr[FRAME_W-1:0], 1'b1, 1'b0, 1'b0));
              hits++;
            end
          end
        end
        if (hits == 0) begin
          due_beats.push_back(make_beat('0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          tail = due_beats.pop_back();
          tail.last = 1'b1;
          due_beats.push_back(tail);
        end
      end
      default: begin
        if (kind == KIND_CLEAR) stored_count = 0;
        due_beats.push_back(make_beat('0, '0, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    sched_beat_t got, want;
    if (!rst_n) begin
      stored_count = 0;
      issue_id = '0;
      fail_count = 0;
      due_beats.delete();
    end else begin
      if (in_tvalid && in_tready) schedule_command(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = make_beat(out_tdata[15:0], out_tdata[21:16], out_tuser[0], out_tuser[1],
                        out_tlast);
        if (due_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = due_beats.pop_front();
          if (got !== want || out_tdata[OUT_DATA_W-1:22] !== '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: id %0d/%0d frame %0d/%0d valid %b/%b full %b/%b last %b/%b",
                       want.event_id, got.event_id, want.frame_index, got.frame_index,
                       want.valid_res, got.valid_res, want.table_full, got.table_full,
                       want.last, got.last);
          end
        end
      end
    end
  end

endmodule

>>> dv/timed_event_window_scheduler_unit_test.sv
`timescale 1ns / 100ps
// Stimulus for the event window scheduler. The checker beside the block
// predicts every result beat; this module only drives commands, idles both
// sides and decides the verdict.
module timed_event_window_scheduler_unit_test;
  import tews_pkg::*;

  // The one kind code the block ignores.
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  int                    fail_count;
  int                    pending_beats;
  bit                    hold_receiver;
  int                    receiver_gap;

  timed_event_window_scheduler_unit u_top (.*);

  tews_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Time base that keeps event times clustered so that windows catch several hits.
  logic [TIME_W-1:0] cluster_base;

  // Drives one command beat and waits for it to be taken. Valid is only
  // lowered when the next beat comes after a gap.
  task automatic send_command(logic [1:0] kind, logic [TIME_W-1:0] t, logic [TIME_W-1:0] ws,
                              logic [TIME_W-1:0] we, logic [OFF_W-1:0] off,
                              logic [LEN_W-1:0] len, bit allow_gap);
    int                   gap;
    logic [IN_DATA_W-1:0] beat;
    gap = allow_gap ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    beat = '0;
    beat[39:0]    = t;
    beat[79:40]   = ws;
    beat[119:80]  = we;
    beat[125:120] = off;
    beat[132:126] = len;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_insert(logic [TIME_W-1:0] t);
    send_command(KIND_INSERT, t, TIME_W'($urandom), TIME_W'($urandom), OFF_W'($urandom),
                 LEN_W'($urandom), 1'b1);
  endtask

  // A run command with an arbitrary offset and a length kept in the legal range.
  task automatic send_run(logic [TIME_W-1:0] ws, logic [TIME_W-1:0] we);
    send_command(KIND_RUN, TIME_W'($urandom), ws, we, OFF_W'($urandom_range(0, 63)),
                 LEN_W'($urandom_range(1, 64)), 1'b1);
  endtask

  function automatic logic [TIME_W-1:0] random_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_beats != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Receiver: draws a stall per beat; one long hold-off is forced on request.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_receiver = 1'b0;
      end
      if (receiver_gap > 0) begin
        receiver_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready) receiver_gap = ($urandom_range(0, 3) == 0) ? 0
                                                   : $urandom_range(0, 5);
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] ws, span;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_INSERT;
    hold_receiver = 1'b0;
    receiver_gap = 0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty table run, extreme times, ties, a reversed window,
    // rounding and clamping, and the unknown kind.
    send_run('0, {TIME_W{1'b1}});
    send_insert({TIME_W{1'b1}});
    send_insert('0);
    send_insert(40'd100);
    send_insert(40'd100);
    send_insert(40'd150);
    send_command(KIND_RUN, '0, 40'd100, 40'd200, 6'd63, 7'd64, 1'b1);
    send_command(KIND_RUN, '0, 40'd0, 40'd2, 6'd0, 7'd1, 1'b1);
    send_command(KIND_RUN, '0, 40'd0, {TIME_W{1'b1}}, 6'd0, 7'd64, 1'b1);
    send_command(KIND_RUN, '0, {TIME_W{1'b1}}, 40'd0, 6'd5, 7'd5, 1'b1);
    send_command(KIND_RUN, '0, 40'd100, 40'd100, 6'd5, 7'd5, 1'b1);
    send_command(KIND_RUN, '0, 40'd99, 40'd101, 6'd0, 7'd3, 1'b1);
    send_command(KIND_UNKNOWN, {TIME_W{1'b1}}, {TIME_W{1'b1}}, {TIME_W{1'b1}}, 6'd63,
                 7'd127, 1'b1);
    send_command(KIND_CLEAR, '0, '0, '0, '0, '0, 1'b1);
    send_run('0, {TIME_W{1'b1}});

    // Fill the table past full while the receiver holds off, so the block
    // backs up into its input.
    hold_receiver = 1'b1;
    for (int i = 0; i < 66; i++) send_insert(40'd1000 + $urandom_range(0, 30));
    send_command(KIND_RUN, '0, 40'd1000, 40'd1031, 6'd0, 7'd64, 1'b1);
    send_command(KIND_RUN, '0, 40'd990, 40'd1040, 6'd63, 7'd64, 1'b1);
    // Pause until every outstanding beat has come back.
    wait_drained();
    send_command(KIND_CLEAR, '0, '0, '0, '0, '0, 1'b1);

    // Random part: mostly small tables in a cluster, runs over them, and
    // occasional clears and stray values.
    cluster_base = random_time();
    for (int i = 0; i < 270; i++) begin
      case ($urandom_range(0, 19))
        0: send_command(KIND_CLEAR, random_time(), random_time(), random_time(),
                        OFF_W'($urandom), LEN_W'($urandom), 1'b1);
        1: send_command(KIND_UNKNOWN, random_time(), random_time(), random_time(),
                        OFF_W'($urandom), LEN_W'($urandom), 1'b1);
        2: send_insert(random_time());
        3: send_command(KIND_RUN, random_time(), random_time(), random_time(),
                        OFF_W'($urandom), LEN_W'($urandom_range(1, 64)), 1'b1);
        4, 5, 6, 7, 8, 9, 10: begin
          if (i % 60 == 0) cluster_base = random_time();
          send_insert(cluster_base + $urandom_range(0, 200));
        end
        default: begin
          ws = cluster_base + $urandom_range(0, 150);
          span = ($urandom_range(0, 4) == 0) ? random_time() >> $urandom_range(0, 39)
                                             : TIME_W'($urandom_range(1, 120));
          send_run(ws, ws + span);
        end
      endcase
    end
    wait_drained();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
